// File: src/pllm_pkg.sv
// Shared types, codes and defaults for the pooled linked list manager.
package pllm_pkg;

	localparam int POOL_SIZE_DEF = 64;

	localparam int CMD_W   = 2;
	localparam int DATA_W  = 32;
	localparam int POS_W   = 6;
	localparam int STAT_W  = 2;
	localparam int IDX_W   = 6;
	localparam int COUNT_W = 7;

	localparam logic [CMD_W-1:0] CMD_PUSH   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_POP    = 2'd1;
	localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;
	localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd3;

	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;
	localparam logic [STAT_W-1:0] ST_RANGE = 2'd3;

	typedef struct packed {
		logic [CMD_W-1:0]  command;
		logic [DATA_W-1:0] payload;
		logic [POS_W-1:0]  position;
	} req_t;

	typedef struct packed {
		logic [STAT_W-1:0]  status;
		logic [IDX_W-1:0]   node_index;
		logic [COUNT_W-1:0] element_count;
	} rsp_t;

endpackage

// File: src/pooled_linked_list_manager_top.sv
// Pooled singly linked list manager: command sequencer around the node memory.
// Steps: push searches for a free node, then walks to the tail when the list is not empty;
// pop and remove-at walk the list; errors skip both; the clear command sweeps the node memory.
// Throughput: one command at a time; the list walk and the free-node scan go through the
// single read port of the node memory, one node per cycle.
// Reset: arst_n clears control; the block then sweeps every node of the node memory
// with req_ready low before the first command is taken.
module pooled_linked_list_manager_top #(
	parameter int POOL_SIZE = pllm_pkg::POOL_SIZE_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  pllm_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output pllm_pkg::rsp_t rsp
);

	import pllm_pkg::*;

	localparam int AW = $clog2(POOL_SIZE);
	localparam int LW = $clog2(POOL_SIZE + 1);
	localparam int NW = LW + 1;
	localparam logic [LW-1:0] LINK_NONE = LW'(POOL_SIZE);
	localparam logic [LW-1:0] CNT_LAST  = LW'(POOL_SIZE - 1);
	localparam logic [AW-1:0] LAST_IDX  = AW'(POOL_SIZE - 1);

	localparam logic [2:0] S_CLEAR  = 3'd0;
	localparam logic [2:0] S_IDLE   = 3'd1;
	localparam logic [2:0] S_SEARCH = 3'd2;
	localparam logic [2:0] S_ALLOC  = 3'd3;
	localparam logic [2:0] S_WALK   = 3'd4;
	localparam logic [2:0] S_FIN1   = 3'd5;
	localparam logic [2:0] S_FIN2   = 3'd6;
	localparam logic [2:0] S_DONE   = 3'd7;

	logic [2:0]        state_q;
	logic [LW-1:0]     head_q;
	logic [LW-1:0]     len_q;
	logic [AW-1:0]     start_q;
	logic [CMD_W-1:0]  cmd_q;
	logic [POS_W-1:0]  pos_q;
	logic [DATA_W-1:0] data_q;
	logic [AW-1:0]     scan_q;
	logic [LW-1:0]     cnt_q;
	logic [AW-1:0]     scan_s1;
	logic              srch_v_s1;
	logic              last_s1;
	logic [AW-1:0]     found_q;
	logic [LW-1:0]     cur_q;
	logic [LW-1:0]     prev_q;
	logic [LW-1:0]     steps_q;
	logic [LW-1:0]     curlink_q;
	logic [AW-1:0]     clr_q;
	logic              clr_rsp_q;
	rsp_t              pend_q;
	rsp_t              rsp_q;
	logic              rsp_valid_q;

	logic              node_we;
	logic [AW-1:0]     node_waddr;
	logic [NW-1:0]     node_wdata;
	logic [AW-1:0]     node_raddr;
	logic [NW-1:0]     node_rdata;
	logic              rd_active;
	logic [LW-1:0]     rd_link;
	logic              walk_stop;

	function automatic logic [AW-1:0] next_idx(input logic [AW-1:0] i);
		return (i == LAST_IDX) ? '0 : i + 1'b1;
	endfunction

	assign rd_active = node_rdata[LW];
	assign rd_link   = node_rdata[LW-1:0];

	// Remove stops at the requested position, pop and append stop at the tail.
	always_comb begin
		if (cmd_q == CMD_REMOVE) begin
			walk_stop = (32'(steps_q) == 32'(pos_q));
		end else begin
			walk_stop = (rd_link >= LINK_NONE) || (steps_q == LINK_NONE);
		end
	end

	always_comb begin
		node_we    = 1'b0;
		node_waddr = clr_q;
		node_wdata = {1'b0, LINK_NONE};
		node_raddr = head_q[AW-1:0];
		unique case (state_q)
			S_CLEAR: begin
				node_we = 1'b1;
			end
			S_SEARCH: begin
				node_raddr = scan_q;
			end
			S_ALLOC: begin
				node_we    = 1'b1;
				node_waddr = found_q;
				node_wdata = {1'b1, LINK_NONE};
			end
			S_WALK: begin
				node_raddr = rd_link[AW-1:0];
			end
			S_FIN1: begin
				node_we    = 1'b1;
				node_waddr = cur_q[AW-1:0];
				if (cmd_q == CMD_PUSH) begin
					node_wdata = {1'b1, LW'(found_q)};
				end else begin
					node_wdata = {1'b0, curlink_q};
				end
			end
			S_FIN2: begin
				node_we    = 1'b1;
				node_waddr = prev_q[AW-1:0];
				node_wdata = {1'b1, (cmd_q == CMD_POP) ? LINK_NONE : curlink_q};
			end
			default: begin
			end
		endcase
	end

	pllm_ram #(
		.WIDTH(NW),
		.DEPTH(POOL_SIZE)
	) u_node_ram (
		.clk  (clk),
		.we   (node_we),
		.waddr(node_waddr),
		.wdata(node_wdata),
		.re   (1'b1),
		.raddr(node_raddr),
		.rdata(node_rdata)
	);

	// Payload words are stored for the data path but no result reads them back.
	pllm_ram #(
		.WIDTH(DATA_W),
		.DEPTH(POOL_SIZE)
	) u_payload_ram (
		.clk  (clk),
		.we   (state_q == S_ALLOC),
		.waddr(found_q),
		.wdata(data_q),
		.re   (1'b0),
		.raddr(found_q),
		.rdata()
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			head_q      <= '0;
			len_q       <= '0;
			start_q     <= '0;
			cmd_q       <= CMD_PUSH;
			pos_q       <= '0;
			data_q      <= '0;
			scan_q      <= '0;
			cnt_q       <= '0;
			scan_s1     <= '0;
			srch_v_s1   <= 1'b0;
			last_s1     <= 1'b0;
			found_q     <= '0;
			cur_q       <= '0;
			prev_q      <= '0;
			steps_q     <= '0;
			curlink_q   <= '0;
			clr_q       <= '0;
			clr_rsp_q   <= 1'b0;
			pend_q      <= '0;
			rsp_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_valid_q && rsp_ready && state_q != S_DONE) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= next_idx(clr_q);
					if (clr_q == LAST_IDX) begin
						clr_rsp_q <= 1'b0;
						if (clr_rsp_q) begin
							pend_q  <= '{status: ST_OK, node_index: '0, element_count: '0};
							state_q <= S_DONE;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				S_IDLE: begin
					if (req_valid) begin
						cmd_q   <= req.command;
						pos_q   <= req.position;
						data_q  <= req.payload;
						cur_q   <= head_q;
						prev_q  <= LINK_NONE;
						steps_q <= '0;
						unique case (req.command)
							CMD_PUSH: begin
								if (len_q >= LINK_NONE) begin
									pend_q  <= '{status: ST_FULL, node_index: '0,
										element_count: COUNT_W'(len_q)};
									state_q <= S_DONE;
								end else begin
									scan_q  <= start_q;
									cnt_q   <= '0;
									state_q <= S_SEARCH;
								end
							end
							CMD_POP: begin
								if (len_q == '0) begin
									pend_q  <= '{status: ST_EMPTY, node_index: '0,
										element_count: COUNT_W'(len_q)};
									state_q <= S_DONE;
								end else begin
									state_q <= S_WALK;
								end
							end
							CMD_REMOVE: begin
								if (32'(req.position) >= 32'(len_q)) begin
									pend_q  <= '{status: ST_RANGE, node_index: '0,
										element_count: COUNT_W'(len_q)};
									state_q <= S_DONE;
								end else begin
									state_q <= S_WALK;
								end
							end
							CMD_CLEAR: begin
								head_q    <= '0;
								len_q     <= '0;
								start_q   <= '0;
								clr_q     <= '0;
								clr_rsp_q <= 1'b1;
								state_q   <= S_CLEAR;
							end
							default: begin
							end
						endcase
					end
				end
				S_SEARCH: begin
					// Issue one probe a cycle; check the probe issued the cycle before.
					srch_v_s1 <= (cnt_q != LINK_NONE) &&
						!(srch_v_s1 && (!rd_active || last_s1));
					if (cnt_q != LINK_NONE) begin
						scan_s1 <= scan_q;
						last_s1 <= (cnt_q == CNT_LAST);
						scan_q  <= next_idx(scan_q);
						cnt_q   <= cnt_q + 1'b1;
					end
					if (srch_v_s1) begin
						if (!rd_active) begin
							found_q <= scan_s1;
							state_q <= S_ALLOC;
						end else if (last_s1) begin
							pend_q  <= '{status: ST_FULL, node_index: '0,
								element_count: COUNT_W'(len_q)};
							state_q <= S_DONE;
						end
					end
				end
				S_ALLOC: begin
					start_q <= next_idx(found_q);
					if (len_q == '0) begin
						head_q  <= LW'(found_q);
						len_q   <= len_q + 1'b1;
						pend_q  <= '{status: ST_OK, node_index: IDX_W'(found_q),
							element_count: COUNT_W'(len_q + 1'b1)};
						state_q <= S_DONE;
					end else begin
						state_q <= S_WALK;
					end
				end
				S_WALK: begin
					if (walk_stop) begin
						curlink_q <= rd_link;
						state_q   <= S_FIN1;
					end else begin
						cur_q   <= rd_link;
						prev_q  <= cur_q;
						steps_q <= steps_q + 1'b1;
					end
				end
				S_FIN1: begin
					if (cmd_q == CMD_PUSH) begin
						len_q   <= len_q + 1'b1;
						pend_q  <= '{status: ST_OK, node_index: IDX_W'(found_q),
							element_count: COUNT_W'(len_q + 1'b1)};
						state_q <= S_DONE;
					end else begin
						len_q  <= len_q - 1'b1;
						pend_q <= '{status: ST_OK, node_index: '0,
							element_count: COUNT_W'(len_q - 1'b1)};
						if (prev_q < LINK_NONE) begin
							state_q <= S_FIN2;
						end else begin
							// Removing the head moves the head to its successor.
							if (cmd_q == CMD_REMOVE) begin
								head_q <= curlink_q;
							end
							state_q <= S_DONE;
						end
					end
				end
				S_FIN2: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!rsp_valid_q || rsp_ready) begin
						rsp_q       <= pend_q;
						rsp_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef SYNTHESIS
	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LINK_NONE)
		else $error("element count exceeds pool size");

	a_err_index: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != ST_OK |-> rsp.node_index == '0)
		else $error("failed command reports a node index");

	a_idle_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE || state_q == S_DONE |-> !node_we)
		else $error("node memory written outside a command");

	a_prev_valid: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FIN2 |-> prev_q < LINK_NONE)
		else $error("predecessor write without a predecessor");

	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_WALK |-> steps_q <= LINK_NONE)
		else $error("list walk ran past the pool size");
`endif

endmodule

// File: src/pllm_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module pllm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: verif/testbench.sv
// Self-checking testbench for the pooled linked list manager: directed table, then random traffic.
`timescale 1ns / 1ps

module testbench;
	import pllm_pkg::*;

	localparam int POOL          = POOL_SIZE_DEF;
	localparam int LINK_NONE     = POOL;
	localparam int NUM_DIRECTED  = 21;
	localparam int RANDOM_ITEMS  = 1430;
	localparam int STALL_LIMIT   = 4000;
	localparam int SETTLE_CYCLES = 200;

	typedef struct {
		logic [CMD_W-1:0]  command;
		logic [DATA_W-1:0] payload;
		logic [POS_W-1:0]  position;
		bit                typed;
		rsp_t              want;
	} dir_row_t;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	req_t req;
	logic rsp_valid;
	logic rsp_ready;
	rsp_t rsp;

	// Shadow copy of the node pool
	bit               slot_used [POOL];
	logic [COUNT_W-1:0] link_of [POOL];
	logic [COUNT_W-1:0] head_slot;
	logic [COUNT_W-1:0] list_len;
	logic [IDX_W-1:0]   next_fit;

	rsp_t        pending_results [$];
	int unsigned mismatch_count = 0;
	int unsigned cycle_count = 0;
	bit          gaps_on;

	// Rows with a typed result are checked against it; the rest against the shadow pool
	dir_row_t directed_rows [NUM_DIRECTED] = '{
		'{CMD_POP,    32'h0000_0000, 6'd0,  1'b1, '{ST_EMPTY, 6'd0, 7'd0}},
		'{CMD_REMOVE, 32'h0000_0000, 6'd0,  1'b1, '{ST_RANGE, 6'd0, 7'd0}},
		'{CMD_REMOVE, 32'hFFFF_FFFF, 6'd63, 1'b1, '{ST_RANGE, 6'd0, 7'd0}},
		'{CMD_PUSH,   32'h0000_0000, 6'd63, 1'b1, '{ST_OK,    6'd0, 7'd1}},
		'{CMD_PUSH,   32'hFFFF_FFFF, 6'd0,  1'b1, '{ST_OK,    6'd1, 7'd2}},
		'{CMD_PUSH,   32'hA5A5_A5A5, 6'd21, 1'b0, '0},
		'{CMD_PUSH,   32'h5A5A_5A5A, 6'd42, 1'b0, '0},
		'{CMD_REMOVE, 32'h0000_0000, 6'd3,  1'b0, '0},
		'{CMD_REMOVE, 32'h0000_0000, 6'd3,  1'b0, '0},
		'{CMD_REMOVE, 32'h0000_0000, 6'd0,  1'b0, '0},
		'{CMD_PUSH,   32'h1234_5678, 6'd0,  1'b0, '0},
		'{CMD_REMOVE, 32'h0000_0000, 6'd1,  1'b0, '0},
		'{CMD_POP,    32'h0000_0000, 6'd0,  1'b0, '0},
		'{CMD_POP,    32'h0000_0000, 6'd0,  1'b0, '0},
		'{CMD_POP,    32'hFFFF_FFFF, 6'd63, 1'b1, '{ST_EMPTY, 6'd0, 7'd0}},
		'{CMD_PUSH,   32'hDEAD_BEEF, 6'd0,  1'b0, '0},
		'{CMD_PUSH,   32'h0F0F_0F0F, 6'd0,  1'b0, '0},
		'{CMD_CLEAR,  32'hFFFF_FFFF, 6'd63, 1'b1, '{ST_OK,    6'd0, 7'd0}},
		'{CMD_PUSH,   32'h0000_0001, 6'd0,  1'b1, '{ST_OK,    6'd0, 7'd1}},
		'{CMD_REMOVE, 32'h0000_0000, 6'd0,  1'b1, '{ST_OK,    6'd0, 7'd0}},
		'{CMD_CLEAR,  32'h0000_0000, 6'd0,  1'b1, '{ST_OK,    6'd0, 7'd0}}
	};

	pooled_linked_list_manager_top #(
		.POOL_SIZE(POOL)
	) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
	end

	always @(posedge clk) cycle_count <= cycle_count + 1;

	function automatic void clear_pool_model();
		for (int k = 0; k < POOL; k++) begin
			slot_used[k] = 1'b0;
			link_of[k]   = COUNT_W'(LINK_NONE);
		end
		head_slot = '0;
		list_len  = '0;
		next_fit  = '0;
	endfunction

	// Walk from the head to the last node, bounded to one pass over the pool
	function automatic int unsigned walk_to_tail(output int unsigned prev);
		int unsigned cur;
		cur  = 32'(head_slot);
		prev = LINK_NONE;
		for (int k = 0; k < POOL; k++) begin
			if (cur >= POOL) break;
			if (link_of[cur] >= POOL) break;
			prev = cur;
			cur  = 32'(link_of[cur]);
		end
		return cur;
	endfunction

	function automatic rsp_t apply_command(req_t item);
		rsp_t        res;
		int unsigned i;
		int unsigned found;
		int unsigned tail;
		int unsigned prev;
		int unsigned cur;
		res = '0;
		res.status = ST_OK;
		case (item.command)
			CMD_PUSH: begin
				if (list_len >= POOL) begin
					res.status = ST_FULL;
				end else begin
					found = LINK_NONE;
					i = 32'(next_fit);
					// next-fit: scan from the rotating start, wrap at the end
					for (int k = 0; k < POOL; k++) begin
						if (!slot_used[i]) begin
							found = i;
							break;
						end
						i = (i + 1 >= POOL) ? 0 : i + 1;
					end
					if (found == LINK_NONE) begin
						res.status = ST_FULL;
					end else begin
						slot_used[found] = 1'b1;
						link_of[found]   = COUNT_W'(LINK_NONE);
						next_fit = IDX_W'((found + 1 >= POOL) ? 0 : found + 1);
						if (list_len == 0) begin
							head_slot = COUNT_W'(found);
						end else begin
							tail = walk_to_tail(prev);
							if (tail < POOL) link_of[tail] = COUNT_W'(found);
						end
						list_len++;
						res.node_index = IDX_W'(found);
					end
				end
			end
			CMD_POP: begin
				if (list_len == 0) begin
					res.status = ST_EMPTY;
				end else begin
					tail = walk_to_tail(prev);
					if (tail < POOL) slot_used[tail] = 1'b0;
					if (prev < POOL) link_of[prev] = COUNT_W'(LINK_NONE);
					list_len--;
				end
			end
			CMD_REMOVE: begin
				if (item.position >= list_len) begin
					res.status = ST_RANGE;
				end else begin
					cur  = 32'(head_slot);
					prev = LINK_NONE;
					for (int k = 0; k < item.position && k < POOL; k++) begin
						if (cur >= POOL) break;
						prev = cur;
						cur  = 32'(link_of[cur]);
					end
					if (cur < POOL) begin
						slot_used[cur] = 1'b0;
						if (prev < POOL) link_of[prev] = link_of[cur];
						else head_slot = link_of[cur];
					end
					list_len--;
				end
			end
			default: clear_pool_model();
		endcase
		res.element_count = list_len;
		return res;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 19);
		if (r < 11) return 0;
		if (r < 18) return $urandom_range(1, 3);
		return $urandom_range(10, 50);
	endfunction

	function automatic req_t make_item(logic [CMD_W-1:0] command, logic [POS_W-1:0] position);
		req_t item;
		item.command  = command;
		item.payload  = $urandom;
		item.position = position;
		return item;
	endfunction

	// Offer one beat, hold it until accepted, then log what it must produce
	task automatic issue(input req_t item, input bit typed, input rsp_t want, input bit drain);
		rsp_t predicted;
		int   gap;
		req       <= item;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_ready !== 1'b1);
		predicted = apply_command(item);
		pending_results.push_back(typed ? want : predicted);
		gap = gaps_on ? pick_gap() : 0;
		if (gap > 0 || drain) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
			while (drain && pending_results.size() != 0) @(posedge clk);
		end
	endtask

	function automatic logic [POS_W-1:0] pick_position();
		if (list_len > 0 && $urandom_range(0, 3) != 0)
			return POS_W'($urandom_range(0, list_len - 1));
		return POS_W'($urandom_range(0, 63));
	endfunction

	initial begin
		req_t item;
		int   sent;
		int   mode;
		int   n;
		int   r;
		clear_pool_model();
		req_valid = 1'b0;
		req       = '0;
		gaps_on   = 1'b1;
		while (arst_n !== 1'b1) @(posedge clk);

		for (int row = 0; row < NUM_DIRECTED; row++) begin
			item.command  = directed_rows[row].command;
			item.payload  = directed_rows[row].payload;
			item.position = directed_rows[row].position;
			// pause at the end of the table until every result is back
			issue(item, directed_rows[row].typed, directed_rows[row].want,
				row == NUM_DIRECTED - 1);
		end

		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			mode    = $urandom_range(0, 9);
			gaps_on = ($urandom_range(0, 3) != 0);
			if (mode <= 2) begin
				// fill the pool, then push a few more into a full pool
				n = POOL - list_len + $urandom_range(1, 3);
				for (int k = 0; k < n; k++) begin
					issue(make_item(CMD_PUSH, POS_W'($urandom_range(0, 63))), 1'b0, '0, 1'b0);
					sent++;
				end
			end else if (mode <= 4) begin
				while (list_len > 0) begin
					if ($urandom_range(0, 1) == 0)
						issue(make_item(CMD_POP, POS_W'($urandom_range(0, 63))), 1'b0, '0, 1'b0);
					else
						issue(make_item(CMD_REMOVE, POS_W'($urandom_range(0, list_len - 1))),
							1'b0, '0, 1'b0);
					sent++;
				end
				// hit the empty list once more
				if ($urandom_range(0, 1) == 0)
					issue(make_item(CMD_POP, '0), 1'b0, '0, 1'b0);
				else
					issue(make_item(CMD_REMOVE, POS_W'($urandom_range(0, 63))), 1'b0, '0, 1'b0);
				sent++;
			end else if (mode <= 8) begin
				n = $urandom_range(20, 60);
				for (int k = 0; k < n; k++) begin
					r = $urandom_range(0, 99);
					if (r < 42)
						item = make_item(CMD_PUSH, POS_W'($urandom_range(0, 63)));
					else if (r < 62)
						item = make_item(CMD_POP, POS_W'($urandom_range(0, 63)));
					else if (r < 97)
						item = make_item(CMD_REMOVE, pick_position());
					else
						item = make_item(CMD_CLEAR, POS_W'($urandom_range(0, 63)));
					issue(item, 1'b0, '0, 1'b0);
					sent++;
				end
			end else begin
				issue(make_item(CMD_CLEAR, POS_W'($urandom_range(0, 63))), 1'b0, '0, 1'b1);
				sent++;
			end
			if ($urandom_range(0, 5) == 0) begin
				issue(make_item(CMD_PUSH, pick_position()), 1'b0, '0, 1'b1);
				sent++;
			end
		end

		req_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && pending_results.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Result side: random stalls, calm stretches, and one long hold-off
	initial begin
		int stall_left;
		bit long_hold_done;
		bit calm;
		stall_left     = 0;
		long_hold_done = 1'b0;
		rsp_ready      = 1'b0;
		forever begin
			@(posedge clk);
			calm = (cycle_count[11:10] == 2'b00);
			if (!long_hold_done && cycle_count >= 4000) begin
				long_hold_done = 1'b1;
				stall_left = 600;
			end else if (stall_left == 0 && !calm && $urandom_range(0, 9) == 0) begin
				stall_left = pick_gap();
			end
			if (stall_left > 0) begin
				rsp_ready <= 1'b0;
				stall_left--;
			end else begin
				rsp_ready <= 1'b1;
			end
		end
	end

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0d got %0d", $time, name, want, got);
			mismatch_count++;
		end
	endfunction

	always @(posedge clk) begin
		rsp_t want;
		if (rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
			if (pending_results.size() == 0) begin
				$display("%0t: result beat with nothing pending, expected none got %0d/%0d/%0d",
					$time, rsp.status, rsp.node_index, rsp.element_count);
				mismatch_count++;
			end else begin
				want = pending_results.pop_front();
				check_field("status", 32'(want.status), 32'(rsp.status));
				check_field("node_index", 32'(want.node_index), 32'(rsp.node_index));
				check_field("element_count", 32'(want.element_count),
					32'(rsp.element_count));
			end
		end
	end

	// Stop if no beat moves on either side for too long
	initial begin
		int idle;
		idle = 0;
		while (idle < STALL_LIMIT) begin
			@(posedge clk);
			if ((req_valid === 1'b1 && req_ready === 1'b1) ||
			    (rsp_valid === 1'b1 && rsp_ready === 1'b1))
				idle = 0;
			else
				idle++;
		end
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// File: sim.f
src/pllm_pkg.sv
src/pllm_ram.sv
src/pooled_linked_list_manager_top.sv
verif/testbench.sv
